[rtl/core/alscd_pkg.sv]
package alscd_pkg;

   localparam int DEPTH         = 64;
   localparam int VALUE_BITS    = 32;
   localparam int IDX_BITS      = $clog2(DEPTH);
   localparam int CNT_BITS      = $clog2(DEPTH + 1);
   localparam int REQ_BITS      = 3;
   localparam int OPER_BITS     = 32;
   localparam int STAT_BITS     = 2;
   localparam int TALLY_BITS    = 7;
   localparam int RSP_DATA_BITS = ((TALLY_BITS + OPER_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = STAT_BITS + 1;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_APPEND = 3'd0,
      REQ_SORT   = 3'd1,
      REQ_COUNT  = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_DUMP   = 3'd4
   } req_code_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      SCAN_COUNT,
      SCAN_DELETE,
      SCAN_SORT,
      SCAN_DUMP
   } scan_mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           capture;
      logic           append;
      logic           start;
      scan_mode_type  mode;
      logic           wback;
      logic           commit;
      logic           emit;
      rsp_status_type status;
      logic           tally_cnt;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
      logic full;
      logic empty;
      logic more_pass;
      logic out_free;
   } dp_stat_type;

   function automatic logic [VALUE_BITS-1:0] to_value(input logic signed [OPER_BITS-1:0] x);
      return VALUE_BITS'(x);
   endfunction

   function automatic logic [OPER_BITS-1:0] to_element(input logic signed [VALUE_BITS-1:0] v);
      return OPER_BITS'(v);
   endfunction

endpackage

[rtl/core/alscd_ctrl.sv]
module alscd_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [alscd_pkg::REQ_BITS-1:0]        req_tuser,
   input  alscd_pkg::dp_stat_type                stat,
   output alscd_pkg::dp_cmd_type                 cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NEXT,
      S_SCAN,
      S_WBACK,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   alscd_pkg::scan_mode_type  kind_ff, kind_in;
   alscd_pkg::rsp_status_type est_ff, est_in;
   logic                      ecnt_ff, ecnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.mode      = kind_ff;
      cmd.status    = est_ff;
      cmd.tally_cnt = ecnt_ff;
      state_in      = state_ff;
      kind_in       = kind_ff;
      est_in        = est_ff;
      ecnt_in       = ecnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               est_in      = alscd_pkg::ST_OK;
               ecnt_in     = 1'b0;
               unique case (alscd_pkg::req_code_type'(req_tuser))
                  alscd_pkg::REQ_APPEND: begin
                     cmd.append = !stat.full;
                     est_in     = stat.full ? alscd_pkg::ST_FULL : alscd_pkg::ST_OK;
                     state_in   = S_EMIT;
                  end
                  alscd_pkg::REQ_SORT: begin
                     kind_in  = alscd_pkg::SCAN_SORT;
                     state_in = S_NEXT;
                  end
                  alscd_pkg::REQ_COUNT: begin
                     cmd.start = 1'b1;
                     cmd.mode  = alscd_pkg::SCAN_COUNT;
                     kind_in   = alscd_pkg::SCAN_COUNT;
                     ecnt_in   = 1'b1;
                     state_in  = S_SCAN;
                  end
                  alscd_pkg::REQ_DELETE: begin
                     cmd.start = 1'b1;
                     cmd.mode  = alscd_pkg::SCAN_DELETE;
                     kind_in   = alscd_pkg::SCAN_DELETE;
                     ecnt_in   = 1'b1;
                     state_in  = S_SCAN;
                  end
                  alscd_pkg::REQ_DUMP: begin
                     kind_in = alscd_pkg::SCAN_DUMP;
                     if (stat.empty) begin
                        state_in = S_EMIT;
                     end else begin
                        cmd.start = 1'b1;
                        cmd.mode  = alscd_pkg::SCAN_DUMP;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     est_in   = alscd_pkg::ST_INVALID;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_NEXT: begin
            if (stat.more_pass) begin
               cmd.start = 1'b1;
               cmd.mode  = alscd_pkg::SCAN_SORT;
               state_in  = S_SCAN;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            if (!stat.busy) begin
               unique case (kind_ff)
                  alscd_pkg::SCAN_SORT:   state_in = S_WBACK;
                  alscd_pkg::SCAN_DELETE: begin
                     cmd.commit = 1'b1;
                     state_in   = S_EMIT;
                  end
                  alscd_pkg::SCAN_COUNT:  state_in = S_EMIT;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_WBACK: begin
            cmd.wback = 1'b1;
            state_in  = S_NEXT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= alscd_pkg::SCAN_COUNT;
         est_ff   <= alscd_pkg::ST_OK;
         ecnt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         est_ff   <= est_in;
         ecnt_ff  <= ecnt_in;
      end
   end

endmodule

[rtl/core/alscd_datapath.sv]
module alscd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [alscd_pkg::OPER_BITS-1:0]        req_operand,
   input  alscd_pkg::dp_cmd_type                  cmd,
   output alscd_pkg::dp_stat_type                 stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [alscd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic [alscd_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   output logic                                   rsp_tlast
);

   logic [alscd_pkg::VALUE_BITS-1:0] mem [alscd_pkg::DEPTH];

   logic [alscd_pkg::CNT_BITS-1:0]   fill_ff, fill_in;
   logic [alscd_pkg::CNT_BITS-1:0]   ptr_ff, ptr_in;
   logic [alscd_pkg::CNT_BITS-1:0]   end_ff, end_in;
   logic [alscd_pkg::CNT_BITS-1:0]   base_ff, base_in;
   logic [alscd_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   alscd_pkg::scan_mode_type         mode_ff, mode_in;
   logic [alscd_pkg::VALUE_BITS-1:0] oper_ff, oper_in;
   logic [alscd_pkg::VALUE_BITS-1:0] pivot_ff, pivot_in;
   logic [alscd_pkg::VALUE_BITS-1:0] rdata_ff;
   logic                             rvld_ff, rvld_in;
   logic [alscd_pkg::IDX_BITS-1:0]   ridx_ff, ridx_in;

   logic                             out_vld_ff, out_vld_in;
   alscd_pkg::rsp_status_type        out_st_ff, out_st_in;
   logic [alscd_pkg::TALLY_BITS-1:0] out_tally_ff, out_tally_in;
   logic [alscd_pkg::OPER_BITS-1:0]  out_elem_ff, out_elem_in;
   logic                             out_ev_ff, out_ev_in;
   logic                             out_last_ff, out_last_in;

   logic                             out_free, go, rd_more, rd_en, proc;
   logic                             is_match, hit_base, hit_last, swap;
   logic                             we;
   logic [alscd_pkg::IDX_BITS-1:0]   waddr;
   logic [alscd_pkg::VALUE_BITS-1:0] wdata;

   assign out_free = !out_vld_ff || rsp_tready;
   // Only a dump stalls the read pipeline on the result channel.
   assign go       = (mode_ff != alscd_pkg::SCAN_DUMP) || out_free;
   assign rd_more  = (ptr_ff < end_ff);
   assign rd_en    = go && rd_more && !cmd.start;
   assign proc     = go && rvld_ff;
   assign is_match = (rdata_ff == oper_ff);
   assign hit_base = (alscd_pkg::CNT_BITS'(ridx_ff) == base_ff);
   assign hit_last = ((alscd_pkg::CNT_BITS'(ridx_ff) + alscd_pkg::CNT_BITS'(1)) == end_ff);
   assign swap     = ($signed(pivot_ff) > $signed(rdata_ff));

   assign stat.busy      = rd_more || rvld_ff;
   assign stat.full      = (fill_ff == alscd_pkg::CNT_BITS'(alscd_pkg::DEPTH));
   assign stat.empty     = (fill_ff == '0);
   assign stat.more_pass = ((base_ff + alscd_pkg::CNT_BITS'(1)) < fill_ff);
   assign stat.out_free  = out_free;

   always_comb begin
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      oper_in      = oper_ff;
      pivot_in     = pivot_ff;
      rvld_in      = rvld_ff;
      ridx_in      = ridx_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_st_in    = out_st_ff;
      out_tally_in = out_tally_ff;
      out_elem_in  = out_elem_ff;
      out_ev_in    = out_ev_ff;
      out_last_in  = out_last_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;

      if (cmd.capture) begin
         oper_in = alscd_pkg::to_value(req_operand);
         base_in = '0;
         cnt_in  = '0;
      end

      if (cmd.append) begin
         we      = 1'b1;
         waddr   = fill_ff[alscd_pkg::IDX_BITS-1:0];
         wdata   = alscd_pkg::to_value(req_operand);
         fill_in = fill_ff + alscd_pkg::CNT_BITS'(1);
      end

      if (cmd.start) begin
         mode_in = cmd.mode;
         ptr_in  = (cmd.mode == alscd_pkg::SCAN_SORT) ? base_ff : '0;
         end_in  = fill_ff;
         rvld_in = 1'b0;
      end else if (go) begin
         rvld_in = rd_more;
         if (rd_more) begin
            ptr_in  = ptr_ff + alscd_pkg::CNT_BITS'(1);
            ridx_in = ptr_ff[alscd_pkg::IDX_BITS-1:0];
         end
      end

      if (proc) begin
         case (mode_ff)
            alscd_pkg::SCAN_COUNT: begin
               if (is_match) begin
                  cnt_in = cnt_ff + alscd_pkg::CNT_BITS'(1);
               end
            end
            alscd_pkg::SCAN_DELETE: begin
               // Survivors are packed down behind the read pointer.
               if (!is_match) begin
                  we     = 1'b1;
                  waddr  = cnt_ff[alscd_pkg::IDX_BITS-1:0];
                  wdata  = rdata_ff;
                  cnt_in = cnt_ff + alscd_pkg::CNT_BITS'(1);
               end
            end
            alscd_pkg::SCAN_SORT: begin
               // The smallest entry of the pass so far lives in the pivot register until write-back to the pass base.
               if (hit_base) begin
                  pivot_in = rdata_ff;
               end else if (swap) begin
                  we       = 1'b1;
                  waddr    = ridx_ff;
                  wdata    = pivot_ff;
                  pivot_in = rdata_ff;
               end
            end
            default: begin
               out_vld_in   = 1'b1;
               out_st_in    = alscd_pkg::ST_OK;
               out_tally_in = alscd_pkg::TALLY_BITS'(fill_ff);
               out_elem_in  = alscd_pkg::to_element(rdata_ff);
               out_ev_in    = 1'b1;
               out_last_in  = hit_last;
            end
         endcase
      end

      if (cmd.wback) begin
         we      = 1'b1;
         waddr   = base_ff[alscd_pkg::IDX_BITS-1:0];
         wdata   = pivot_ff;
         base_in = base_ff + alscd_pkg::CNT_BITS'(1);
      end

      if (cmd.commit) begin
         fill_in = cnt_ff;
      end

      if (cmd.emit) begin
         out_vld_in   = 1'b1;
         out_st_in    = cmd.status;
         out_tally_in = alscd_pkg::TALLY_BITS'(cmd.tally_cnt ? cnt_ff : fill_ff);
         out_elem_in  = '0;
         out_ev_in    = 1'b0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[ptr_ff[alscd_pkg::IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         ptr_ff     <= '0;
         end_ff     <= '0;
         base_ff    <= '0;
         cnt_ff     <= '0;
         mode_ff    <= alscd_pkg::SCAN_COUNT;
         rvld_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         ptr_ff     <= ptr_in;
         end_ff     <= end_in;
         base_ff    <= base_in;
         cnt_ff     <= cnt_in;
         mode_ff    <= mode_in;
         rvld_ff    <= rvld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      oper_ff      <= oper_in;
      pivot_ff     <= pivot_in;
      ridx_ff      <= ridx_in;
      out_st_ff    <= out_st_in;
      out_tally_ff <= out_tally_in;
      out_elem_ff  <= out_elem_in;
      out_ev_ff    <= out_ev_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = alscd_pkg::RSP_DATA_BITS'({out_elem_ff, out_tally_ff});
   assign rsp_tuser  = {out_ev_ff, out_st_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/core/array_list_sort_count_delete.sv]
// Append and invalid requests respond without a scan of the list; count and delete read
// the whole list before their response, and a dump returns its entries as the scan reads
// them.
// Throughput: a dump streams one entry per cycle while the receiver keeps rsp_tready high;
// a sort makes one compare per cycle, with one read and at most one write of the entry
// memory, and one pass per list position but the last.
// Reset clears the fill count and all control state; the entry memory is not cleared,
// so the block is ready for a request in the first cycle after reset.
module array_list_sort_count_delete (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata fields from bit 0: operand_value[31:0].
   input  logic [alscd_pkg::OPER_BITS-1:0]     req_tdata,
   // req_tuser fields from bit 0: req_type[2:0].
   input  logic [alscd_pkg::REQ_BITS-1:0]      req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata fields from bit 0: tally[6:0], element[38:7], zero pad[39].
   output logic [alscd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // rsp_tuser fields from bit 0: status[1:0], element_valid[2].
   output logic [alscd_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   output logic                                rsp_tlast
);

   // The controller sequences each request; the datapath owns the entry memory,
   // the scan pipeline (address, registered read, process) and the response register.
   // A response waiting in that register does not block the next request transaction.
   alscd_pkg::dp_cmd_type  cmd;
   alscd_pkg::dp_stat_type stat;

   alscd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   alscd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_operand (req_tdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[rtl/core/alscd_checker.sv]
module alscd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [alscd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [alscd_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input logic                                rsp_tlast
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Every request keeps the block busy for at least the following cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // A response without an entry ends its request and carries a zero element.
   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[alscd_pkg::STAT_BITS] |->
         rsp_tlast && (rsp_tdata[alscd_pkg::TALLY_BITS +: alscd_pkg::OPER_BITS] == '0))
      else $error("entry-less response malformed");

   // Error statuses never come with a list entry.
   a_status_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[alscd_pkg::STAT_BITS-1:0] != alscd_pkg::ST_OK) |->
         !rsp_tuser[alscd_pkg::STAT_BITS] && rsp_tlast)
      else $error("error status with an entry");

   // The tally never exceeds the list depth.
   a_tally_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[alscd_pkg::TALLY_BITS-1:0] <= alscd_pkg::TALLY_BITS'(alscd_pkg::DEPTH)))
      else $error("tally out of range");

endmodule

bind array_list_sort_count_delete alscd_checker u_alscd_checker (.*);

[test/array_list_sort_count_delete_test.sv]
`timescale 1ns / 100ps

module array_list_sort_count_delete_test;

   // Run length and pacing. The cycle limit is far above the slowest legal run:
   // even two sorts of a full list plus many 64-entry dumps against a stalling
   // receiver stay well below it.
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int RANDOM_REQUESTS = 150;
   localparam int CALM_REQUESTS   = 30;
   localparam int SETTLE_CYCLES   = 200;

   // Request codes that the block does not implement.
   localparam logic [alscd_pkg::REQ_BITS-1:0] REQ_RSVD_LO  = 3'd5;
   localparam logic [alscd_pkg::REQ_BITS-1:0] REQ_RSVD_MID = 3'd6;
   localparam logic [alscd_pkg::REQ_BITS-1:0] REQ_RSVD_HI  = 3'd7;

   // One response transaction as the block should present it.
   typedef struct packed {
      alscd_pkg::rsp_status_type          status;
      logic [alscd_pkg::TALLY_BITS-1:0]   tally;
      logic [alscd_pkg::OPER_BITS-1:0]    element;
      logic                               element_valid;
      logic                               last;
   } list_reply_type;

   // One row of the directed sequence. When pinned is set, the single response
   // of that row is the status and tally typed into the row; otherwise the
   // shadow list decides what the responses must be.
   typedef struct packed {
      logic [alscd_pkg::REQ_BITS-1:0]     kind;
      logic [alscd_pkg::OPER_BITS-1:0]    value;
      logic                               pinned;
      alscd_pkg::rsp_status_type          status;
      logic [alscd_pkg::TALLY_BITS-1:0]   tally;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [0:23] = '{
      // Every request but append on an empty list, including an empty dump and a bad code.
      '{alscd_pkg::REQ_DUMP,   32'h0000_0000, 1'b1, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_COUNT,  32'h0000_0000, 1'b1, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_SORT,   32'h0000_0000, 1'b1, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_DELETE, 32'h0000_0005, 1'b1, alscd_pkg::ST_OK,      7'd0},
      '{REQ_RSVD_LO,           32'h0000_0000, 1'b1, alscd_pkg::ST_INVALID, 7'd0},
      // The extremes of the value range, with duplicates, out of order.
      '{alscd_pkg::REQ_APPEND, 32'h7FFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd1},
      '{alscd_pkg::REQ_APPEND, 32'h8000_0000, 1'b1, alscd_pkg::ST_OK,      7'd2},
      '{alscd_pkg::REQ_APPEND, 32'hFFFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd3},
      '{alscd_pkg::REQ_APPEND, 32'h0000_0000, 1'b1, alscd_pkg::ST_OK,      7'd4},
      '{alscd_pkg::REQ_APPEND, 32'h0000_0001, 1'b1, alscd_pkg::ST_OK,      7'd5},
      '{alscd_pkg::REQ_APPEND, 32'h8000_0000, 1'b1, alscd_pkg::ST_OK,      7'd6},
      '{alscd_pkg::REQ_APPEND, 32'h7FFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd7},
      '{alscd_pkg::REQ_COUNT,  32'h8000_0000, 1'b1, alscd_pkg::ST_OK,      7'd2},
      '{REQ_RSVD_MID,          32'hFFFF_FFFF, 1'b1, alscd_pkg::ST_INVALID, 7'd7},
      '{REQ_RSVD_HI,           32'hAAAA_AAAA, 1'b1, alscd_pkg::ST_INVALID, 7'd7},
      '{alscd_pkg::REQ_DUMP,   32'h0000_0000, 1'b0, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_SORT,   32'h5555_5555, 1'b1, alscd_pkg::ST_OK,      7'd7},
      '{alscd_pkg::REQ_DUMP,   32'hFFFF_FFFF, 1'b0, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_DELETE, 32'h8000_0000, 1'b1, alscd_pkg::ST_OK,      7'd5},
      '{alscd_pkg::REQ_DELETE, 32'h0001_2345, 1'b1, alscd_pkg::ST_OK,      7'd5},
      '{alscd_pkg::REQ_COUNT,  32'h7FFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd2},
      '{alscd_pkg::REQ_DELETE, 32'h7FFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd3},
      '{alscd_pkg::REQ_DUMP,   32'h0000_0000, 1'b0, alscd_pkg::ST_OK,      7'd0},
      '{alscd_pkg::REQ_COUNT,  32'hFFFF_FFFF, 1'b1, alscd_pkg::ST_OK,      7'd1}
   };

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [alscd_pkg::OPER_BITS-1:0]     req_tdata  = '0;
   logic [alscd_pkg::REQ_BITS-1:0]      req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [alscd_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [alscd_pkg::RSP_USER_BITS-1:0] rsp_tuser;
   logic                                rsp_tlast;

   // Shadow copy of the list, updated as each request transaction is accepted.
   logic signed [alscd_pkg::VALUE_BITS-1:0] shadow_list [alscd_pkg::DEPTH];
   int                                      shadow_fill = 0;

   // Responses the block still owes, oldest first.
   list_reply_type awaited_replies [$];

   // When set, neither side idles; the tail of the run goes at full rate.
   bit calm = 1'b0;

   int cycle_count    = 0;
   int error_count    = 0;
   int requests_sent  = 0;
   int replies_seen   = 0;
   int sorts_sent     = 0;
   int dumps_sent     = 0;
   int dropped_appends = 0;

   array_list_sort_count_delete dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic list_reply_type plain_reply(input alscd_pkg::rsp_status_type status,
                                                  input int tally);
      list_reply_type reply;
      reply.status        = status;
      reply.tally         = alscd_pkg::TALLY_BITS'(tally);
      reply.element       = '0;
      reply.element_valid = 1'b0;
      reply.last          = 1'b1;
      return reply;
   endfunction

   // Applies one accepted request to the shadow list and queues the responses
   // that it must produce.
   task automatic apply_list_request(input logic [alscd_pkg::REQ_BITS-1:0] kind,
                                     input logic [alscd_pkg::OPER_BITS-1:0] value);
      logic signed [alscd_pkg::VALUE_BITS-1:0] operand;
      logic signed [alscd_pkg::VALUE_BITS-1:0] held;
      list_reply_type                          reply;
      int                                      i;
      int                                      j;
      int                                      kept;
      operand = value;
      case (kind)
         alscd_pkg::REQ_APPEND: begin
            if (shadow_fill >= alscd_pkg::DEPTH) begin
               dropped_appends++;
               awaited_replies.push_back(plain_reply(alscd_pkg::ST_FULL, shadow_fill));
            end else begin
               shadow_list[shadow_fill] = operand;
               shadow_fill++;
               awaited_replies.push_back(plain_reply(alscd_pkg::ST_OK, shadow_fill));
            end
         end
         alscd_pkg::REQ_SORT: begin
            // Exchange sort: each position against every later one, signed order.
            for (i = 0; i + 1 < shadow_fill; i++) begin
               for (j = i + 1; j < shadow_fill; j++) begin
                  if (shadow_list[i] > shadow_list[j]) begin
                     held           = shadow_list[i];
                     shadow_list[i] = shadow_list[j];
                     shadow_list[j] = held;
                  end
               end
            end
            awaited_replies.push_back(plain_reply(alscd_pkg::ST_OK, shadow_fill));
         end
         alscd_pkg::REQ_COUNT: begin
            kept = 0;
            for (i = 0; i < shadow_fill; i++) begin
               if (shadow_list[i] == operand) kept++;
            end
            awaited_replies.push_back(plain_reply(alscd_pkg::ST_OK, kept));
         end
         alscd_pkg::REQ_DELETE: begin
            // Compact the survivors toward the front, keeping their order.
            kept = 0;
            for (i = 0; i < shadow_fill; i++) begin
               if (shadow_list[i] != operand) begin
                  shadow_list[kept] = shadow_list[i];
                  kept++;
               end
            end
            shadow_fill = kept;
            awaited_replies.push_back(plain_reply(alscd_pkg::ST_OK, shadow_fill));
         end
         alscd_pkg::REQ_DUMP: begin
            if (shadow_fill == 0) begin
               awaited_replies.push_back(plain_reply(alscd_pkg::ST_OK, 0));
            end else begin
               for (i = 0; i < shadow_fill; i++) begin
                  reply               = plain_reply(alscd_pkg::ST_OK, shadow_fill);
                  reply.element       = shadow_list[i];
                  reply.element_valid = 1'b1;
                  reply.last          = (i + 1 == shadow_fill);
                  awaited_replies.push_back(reply);
               end
            end
         end
         default: begin
            awaited_replies.push_back(plain_reply(alscd_pkg::ST_INVALID, shadow_fill));
         end
      endcase
   endtask

   // Presents one request, with an occasional idle burst in front of it, and
   // waits for the transaction. The valid stays high from one request to the
   // next unless a burst lowers it.
   task automatic send_request(input logic [alscd_pkg::REQ_BITS-1:0] kind,
                               input logic [alscd_pkg::OPER_BITS-1:0] value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_request(kind, value);
      requests_sent++;
      if (kind == alscd_pkg::REQ_SORT) sorts_sent++;
      if (kind == alscd_pkg::REQ_DUMP) dumps_sent++;
   endtask

   // Operands lean toward values already in the list so that count and delete
   // find matches, with corner values and fully random words mixed in.
   function automatic logic [alscd_pkg::OPER_BITS-1:0] pick_operand();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0000_0000;
               4: return 32'h0000_0001;
               default: return 32'hFFFF_FFFE;
            endcase
         end
         default: begin
            if (shadow_fill > 0) return shadow_list[$urandom_range(0, shadow_fill - 1)];
            return alscd_pkg::OPER_BITS'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // Fills the list to capacity, pushes two appends that must be dropped, and
   // then sorts, dumps and counts over the full list.
   task automatic fill_past_capacity();
      while (shadow_fill < alscd_pkg::DEPTH) send_request(alscd_pkg::REQ_APPEND, pick_operand());
      send_request(alscd_pkg::REQ_APPEND, $urandom());
      send_request(alscd_pkg::REQ_APPEND, 32'h8000_0000);
      send_request(alscd_pkg::REQ_SORT, $urandom());
      send_request(alscd_pkg::REQ_DUMP, $urandom());
      send_request(alscd_pkg::REQ_COUNT, pick_operand());
   endtask

   // Compares one response field and reports a mismatch.
   task automatic check_field(input string name,
                              input logic [alscd_pkg::OPER_BITS-1:0] want,
                              input logic [alscd_pkg::OPER_BITS-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Receiver side: random stall bursts on the response ready, none in the tail.
   initial begin
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Response checker: every response transaction is matched against the
   // oldest outstanding expectation, field by field.
   always @(posedge clock) begin : reply_check
      list_reply_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, tdata %h tuser %h tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", alscd_pkg::OPER_BITS'(want.status),
                        alscd_pkg::OPER_BITS'(rsp_tuser[alscd_pkg::STAT_BITS-1:0]));
            check_field("tally", alscd_pkg::OPER_BITS'(want.tally),
                        alscd_pkg::OPER_BITS'(rsp_tdata[alscd_pkg::TALLY_BITS-1:0]));
            check_field("element", want.element,
                        rsp_tdata[alscd_pkg::TALLY_BITS +: alscd_pkg::OPER_BITS]);
            check_field("element_valid", alscd_pkg::OPER_BITS'(want.element_valid),
                        alscd_pkg::OPER_BITS'(rsp_tuser[alscd_pkg::STAT_BITS]));
            check_field("last", alscd_pkg::OPER_BITS'(want.last),
                        alscd_pkg::OPER_BITS'(rsp_tlast));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d responses outstanding.",
               cycle_count, awaited_replies.size());
      $display("array_list_sort_count_delete_test: errors");
      $finish;
   end

   // Main sequence: reset, the directed table, then the random phase.
   initial begin
      int                             row;
      int                             n;
      int                             roll;
      logic [alscd_pkg::REQ_BITS-1:0] kind;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Pinned rows replace the predicted response with the
      // typed-in one, so those values are checked independently of the shadow.
      for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
         send_request(DIRECTED_ROWS[row].kind, DIRECTED_ROWS[row].value);
         if (DIRECTED_ROWS[row].pinned) begin
            awaited_replies[awaited_replies.size() - 1] =
               plain_reply(DIRECTED_ROWS[row].status, DIRECTED_ROWS[row].tally);
         end
      end

      // Random part. Appends dominate so the list grows; twice the list is
      // driven to capacity and beyond, with a sort and a dump of the full list.
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         calm = (n >= RANDOM_REQUESTS - CALM_REQUESTS);
         if (n == 30 || n == 70) fill_past_capacity();
         roll = $urandom_range(0, 99);
         if (roll < 42)      kind = alscd_pkg::REQ_APPEND;
         else if (roll < 52) kind = alscd_pkg::REQ_SORT;
         else if (roll < 67) kind = alscd_pkg::REQ_COUNT;
         else if (roll < 78) kind = alscd_pkg::REQ_DELETE;
         else if (roll < 92) kind = alscd_pkg::REQ_DUMP;
         else kind = alscd_pkg::REQ_BITS'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
         send_request(kind, pick_operand());
      end
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray response.
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d sorts, %0d dumps, %0d appends dropped on a full list),",
               requests_sent, sorts_sent, dumps_sent, dropped_appends);
      $display("and checked %0d responses with %0d field errors.", replies_seen, error_count);
      if (error_count == 0) begin
         $display("array_list_sort_count_delete_test: clean");
      end else begin
         $display("array_list_sort_count_delete_test: errors");
      end
      $finish;
   end

endmodule
